@@ hdl/vt4_pkg.sv @@
package vt4_pkg;

    localparam int FIELD_W          = 32;
    localparam int OP_W             = 2;
    localparam int IDX_W            = 4;
    localparam int DIM              = 4;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int WORD_WIDTH_DEF   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_VEC   = 2'd1,
        OP_POINT = 2'd2
    } opcode_t;

    typedef struct packed {
        logic cap_term;
        logic cap_sum;
        logic point;
    } vt4_ctl_t;

    typedef struct packed {
        logic cap;
        logic point;
    } vt4_mrg_t;

    function automatic int term_w(input int d, input int f);
        term_w = (2 * d - f > d) ? 2 * d - f : d;
    endfunction

endpackage

@@ hdl/vt4_if.sv @@
interface vt4_in_if;
    import vt4_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic [IDX_W-1:0]           element_index;
    logic signed [FIELD_W-1:0]  element_value;
    logic signed [FIELD_W-1:0]  in_x;
    logic signed [FIELD_W-1:0]  in_y;
    logic signed [FIELD_W-1:0]  in_z;
    logic signed [FIELD_W-1:0]  in_w;

    modport source (
        output valid, opcode, element_index, element_value, in_x, in_y, in_z, in_w,
        input  ready
    );

    modport sink (
        input  valid, opcode, element_index, element_value, in_x, in_y, in_z, in_w,
        output ready
    );
endinterface

interface vt4_out_if;
    import vt4_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  out_x;
    logic signed [FIELD_W-1:0]  out_y;
    logic signed [FIELD_W-1:0]  out_z;
    logic signed [FIELD_W-1:0]  out_w;
    logic                       saturated;

    modport source (
        output valid, out_x, out_y, out_z, out_w, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w, saturated,
        output ready
    );
endinterface

@@ hdl/vt4_lane.sv @@
module vt4_lane #(
    parameter int DATA_W    = 32,
    parameter int FRAC_BITS = 16,
    parameter int SUM_W     = vt4_pkg::term_w(32, 16) + 2
) (
    input  logic                        clk,
    input  vt4_pkg::vt4_ctl_t           ctl,
    input  logic signed [DATA_W-1:0]    vec [vt4_pkg::DIM],
    input  logic signed [DATA_W-1:0]    col [vt4_pkg::DIM],
    output logic signed [SUM_W-1:0]     sum
);
    import vt4_pkg::*;

    localparam int TERM_W = term_w(DATA_W, FRAC_BITS);

    logic signed [2*DATA_W-1:0] prod      [DIM];
    logic signed [2*DATA_W-1:0] shf       [DIM];
    logic signed [TERM_W-1:0]   term_next [DIM];
    logic signed [TERM_W-1:0]   term_reg  [DIM];
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    sum_reg;

    for (genvar c = 0; c < DIM; c++) begin : g_col
        assign prod[c] = vec[c] * col[c];
        assign shf[c]  = prod[c] >>> FRAC_BITS;
        if (c == DIM - 1) begin : g_last
            // point mode: add the translation element as is
            assign term_next[c] = ctl.point ? TERM_W'(col[c]) : shf[c][TERM_W-1:0];
        end
        else begin : g_mul
            assign term_next[c] = shf[c][TERM_W-1:0];
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(term_reg[0]) + SUM_W'(term_reg[1])
                 + SUM_W'(term_reg[2]) + SUM_W'(term_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_term)
        begin
            term_reg <= term_next;
        end
        if (ctl.cap_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

@@ hdl/vt4_merge.sv @@
module vt4_merge #(
    parameter int DATA_W = 32,
    parameter int SUM_W  = vt4_pkg::term_w(32, 16) + 2
) (
    input  logic                                clk,
    input  vt4_pkg::vt4_mrg_t                   ctl,
    input  logic signed [SUM_W-1:0]             sums [vt4_pkg::DIM],
    output logic signed [vt4_pkg::FIELD_W-1:0]  res  [vt4_pkg::DIM],
    output logic                                saturated
);
    import vt4_pkg::*;

    localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_V = ~MAX_V;

    logic                       row_ok   [DIM];
    logic signed [DATA_W-1:0]   row_val  [DIM];
    logic signed [FIELD_W-1:0]  res_next [DIM];
    logic signed [FIELD_W-1:0]  res_reg  [DIM];
    logic                       sat_next;
    logic                       sat_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            row_ok[r] = (&sums[r][SUM_W-1:DATA_W-1]) || !(|sums[r][SUM_W-1:DATA_W-1]);
            if (row_ok[r])
            begin
                row_val[r] = sums[r][DATA_W-1:0];
            end
            else
            begin
                row_val[r] = sums[r][SUM_W-1] ? MIN_V : MAX_V;
            end
            // drop row 3 in point mode
            if (r == DIM - 1 && ctl.point)
            begin
                row_val[r] = '0;
            end
            else
            begin
                sat_next = sat_next | !row_ok[r];
            end
            res_next[r] = FIELD_W'(row_val[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res       = res_reg;
    assign saturated = sat_reg;

endmodule

@@ hdl/vertex_transform_4x4.sv @@
// Transforms vectors by a 4x4 column-major fixed-point matrix held in flops (reset to
// identity). Opcode 0 loads one element at index col*4+row and gives no result; opcode 1
// multiplies by (x,y,z,w); opcode 2 multiplies by (x,y,z,1) and returns out_w as 0; opcode 3
// is dropped. Products are floored by FRAC_BITS, summed exactly per row and saturated to
// min(WORD_WIDTH,32) bits, with saturated set when any returned row clipped. One beat is
// taken every cycle unless result.ready stalls a full pipeline. Four row lanes each run
// four multipliers side by side into term, sum and merge registers; loads hit the next beat.
module vertex_transform_4x4 #(
    parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF,
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vt4_in_if.sink      item,
    vt4_out_if.source   result
);
    import vt4_pkg::*;

    localparam int DATA_W = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;
    localparam int SUM_W  = term_w(DATA_W, FRAC_BITS) + 2;
    localparam int NELEM  = DIM * DIM;

    localparam logic signed [DATA_W-1:0]  MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0]  MIN_V = ~MAX_V;
    localparam logic signed [DATA_W-1:0]  ONE_V =
        (FRAC_BITS >= DATA_W - 1) ? MAX_V : (DATA_W'(1) << FRAC_BITS);
    localparam logic signed [FIELD_W-1:0] MAX_F = FIELD_W'(MAX_V);
    localparam logic signed [FIELD_W-1:0] MIN_F = FIELD_W'(MIN_V);

    logic signed [DATA_W-1:0]   mat_reg [NELEM];
    logic signed [DATA_W-1:0]   vec     [DIM];
    logic signed [SUM_W-1:0]    sums    [DIM];
    logic signed [FIELD_W-1:0]  res     [DIM];

    logic       v1_reg;
    logic       v2_reg;
    logic       out_v_reg;
    logic       pt1_reg;
    logic       pt2_reg;
    logic       accept;
    logic       is_xf;
    logic       adv_out;
    logic       rdy2;
    logic       rdy1;
    vt4_ctl_t   lane_ctl;
    vt4_mrg_t   mrg_ctl;

    assign adv_out = !out_v_reg || result.ready;
    assign rdy2    = !v2_reg || adv_out;
    assign rdy1    = !v1_reg || rdy2;
    assign accept  = item.valid && rdy1;
    assign is_xf   = (item.opcode == OP_VEC) || (item.opcode == OP_POINT);

    assign lane_ctl.cap_term = accept && is_xf;
    assign lane_ctl.cap_sum  = v1_reg && rdy2;
    assign lane_ctl.point    = item.opcode == OP_POINT;
    assign mrg_ctl.cap       = v2_reg && adv_out;
    assign mrg_ctl.point     = pt2_reg;

    assign vec[0] = item.in_x[DATA_W-1:0];
    assign vec[1] = item.in_y[DATA_W-1:0];
    assign vec[2] = item.in_z[DATA_W-1:0];
    assign vec[3] = item.in_w[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NELEM; i++)
            begin
                mat_reg[i] <= (i % (DIM + 1) == 0) ? ONE_V : '0;
            end
        end
        else if (accept && item.opcode == OP_LOAD)
        begin
            mat_reg[item.element_index] <= item.element_value[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            pt1_reg   <= 1'b0;
            pt2_reg   <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg  <= lane_ctl.cap_term;
                pt1_reg <= lane_ctl.point;
            end
            if (rdy2)
            begin
                v2_reg  <= v1_reg;
                pt2_reg <= pt1_reg;
            end
            if (adv_out)
            begin
                out_v_reg <= v2_reg;
            end
        end
    end

    for (genvar r = 0; r < DIM; r++) begin : g_lane
        logic signed [DATA_W-1:0] col [DIM];

        for (genvar c = 0; c < DIM; c++) begin : g_tap
            assign col[c] = mat_reg[c * DIM + r];
        end

        vt4_lane #(
            .DATA_W    (DATA_W),
            .FRAC_BITS (FRAC_BITS),
            .SUM_W     (SUM_W)
        ) u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .vec (vec),
            .col (col),
            .sum (sums[r])
        );
    end

    vt4_merge #(
        .DATA_W (DATA_W),
        .SUM_W  (SUM_W)
    ) u_merge (
        .clk       (clk),
        .ctl       (mrg_ctl),
        .sums      (sums),
        .res       (res),
        .saturated (result.saturated)
    );

    assign item.ready   = rdy1;
    assign result.valid = out_v_reg;
    assign result.out_x = res[0];
    assign result.out_y = res[1];
    assign result.out_z = res[2];
    assign result.out_w = res[3];

    a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_LOAD |=>
            mat_reg[$past(item.element_index)] == $past(item.element_value[DATA_W-1:0]))
        else $error("matrix load not written");

    a_point_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && pt2_reg && adv_out |=> result.valid && result.out_w == '0)
        else $error("point result with nonzero w");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.out_x == MAX_F || result.out_x == MIN_F ||
            result.out_y == MAX_F || result.out_y == MIN_F ||
            result.out_z == MAX_F || result.out_z == MIN_F ||
            result.out_w == MAX_F || result.out_w == MIN_F)
        else $error("saturation flag without clipped row");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> v1_reg && v2_reg && out_v_reg)
        else $error("input stalled with a free stage");

    a_xf_enters: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.cap_term |=> v1_reg)
        else $error("transform beat lost at entry");

endmodule
